[rtl/fbpa_pkg.sv]
// Shared definitions for the fixed block pool allocator: field widths,
// register indexes, operation codes and the controller/datapath structs.
// No dependencies.
package fbpa_pkg;

  localparam int ADDR_W     = 32;
  localparam int SIZE_W     = 16;
  localparam int CNT_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int DEFAULT_MAX_BLOCKS = 64;
  // Flags examined per scan cycle (one row of the flag memory).
  localparam int SCAN_LANES = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT  = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [ADDR_W-1:0] BASE_ADDRESS_RESET = 32'h0000_0000;
  localparam logic [SIZE_W-1:0] BLOCK_SIZE_RESET   = 16'd16;
  localparam logic [CNT_W-1:0]  BLOCK_COUNT_RESET  = 7'd64;

  typedef struct packed {
    logic start;   // latch a new transaction and clear the accumulators
    logic rd;      // read one row of flags
    logic commit;  // write back the chosen flag and load the result
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;  // the row being read is the last active one
    logic out_free;   // the result register can take a new result
  } ctrl_status_t;

endpackage

[rtl/fbpa_ctrl.sv]
// Sequencer of the fixed block pool allocator: accepts a request, walks the
// rows of the flag memory and commits the outcome. Depends on fbpa_pkg.
module fbpa_ctrl #(
  parameter int MAX_BLOCKS = fbpa_pkg::DEFAULT_MAX_BLOCKS,
  localparam int LANES = fbpa_pkg::SCAN_LANES,
  localparam int GRP   = (MAX_BLOCKS + LANES - 1) / LANES,
  localparam int GRP_W = (GRP > 1) ? $clog2(GRP) : 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  output fbpa_pkg::ctrl_cmd_t     cmd,
  output logic [GRP_W-1:0]        grp,
  input  fbpa_pkg::ctrl_status_t  status
);
  import fbpa_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_WAIT   = 2'd2;
  localparam logic [1:0] ST_COMMIT = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [GRP_W-1:0] grp_r, grp_nxt;

  always_comb begin
    state_nxt = state_r;
    grp_nxt   = grp_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.start = 1'b1;
          grp_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.rd = 1'b1;
        if (status.scan_last) begin
          state_nxt = ST_WAIT;
        end else begin
          grp_nxt = grp_r + GRP_W'(1);
        end
      end
      // The last row read is evaluated here.
      ST_WAIT: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      grp_r   <= '0;
    end else begin
      state_r <= state_nxt;
      grp_r   <= grp_nxt;
    end
  end

  assign in_tready = (state_r == ST_IDLE);
  assign grp       = grp_r;

`ifndef ASSERT_OFF
  a_start_scans: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> (state_r == ST_SCAN))
    else $error("request accepted but scan did not begin");
  a_last_row_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && status.scan_last) |=> (state_r == ST_WAIT))
    else $error("scan did not stop after the last row");
  a_commit_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> in_tready)
    else $error("input not ready after commit");
`endif

endmodule

[rtl/fbpa_datapath.sv]
// Datapath of the fixed block pool allocator: flag memory, lane address
// generation and compare, counting, hit capture and the result register.
// Depends on fbpa_pkg.
module fbpa_datapath #(
  parameter int MAX_BLOCKS = fbpa_pkg::DEFAULT_MAX_BLOCKS,
  localparam int LANES = fbpa_pkg::SCAN_LANES,
  localparam int GRP   = (MAX_BLOCKS + LANES - 1) / LANES,
  localparam int GRP_W = (GRP > 1) ? $clog2(GRP) : 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  fbpa_pkg::ctrl_cmd_t            cmd,
  input  logic [GRP_W-1:0]               grp,
  output fbpa_pkg::ctrl_status_t         status,
  input  logic [fbpa_pkg::ADDR_W-1:0]    base_address,
  input  logic [fbpa_pkg::SIZE_W-1:0]    block_size,
  input  logic [fbpa_pkg::CNT_W-1:0]     block_count,
  input  logic                           in_operation,
  input  logic [fbpa_pkg::ADDR_W-1:0]    in_release_address,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_success,
  output logic [fbpa_pkg::ADDR_W-1:0]    out_block_address,
  output logic [fbpa_pkg::CNT_W-1:0]     out_free_count
);
  import fbpa_pkg::*;

  localparam int IW     = $clog2(GRP * LANES + 1);
  localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int CNT_MAX = (1 << CNT_W) - 1;
  localparam logic [CNT_W-1:0] MAX_CNT = (MAX_BLOCKS > CNT_MAX) ? CNT_W'(CNT_MAX)
                                                                : CNT_W'(MAX_BLOCKS);

  // Active block count and the last row it reaches.
  logic [CNT_W-1:0] n_act;
  logic [IW-1:0]    n_ext;
  logic [IW-1:0]    n_m1;
  logic [GRP_W-1:0] last_grp;

  assign n_act    = (block_count > MAX_CNT) ? MAX_CNT : block_count;
  assign n_ext    = IW'(n_act);
  assign n_m1     = n_ext - IW'(1);
  assign last_grp = (n_ext == '0) ? '0 : GRP_W'(n_m1 / LANES);

  // Request registers.
  logic              op_r;
  logic [ADDR_W-1:0] rel_r;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r  <= in_operation;
      rel_r <= in_release_address;
    end
  end

  // Address of lane 0 of the row being read, stepped by one row per read.
  logic [ADDR_W-1:0] issue_addr_r;
  logic [ADDR_W-1:0] grp_step;

  assign grp_step = ADDR_W'(block_size) * ADDR_W'(LANES);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      issue_addr_r <= base_address;
    end else if (cmd.rd) begin
      issue_addr_r <= issue_addr_r + grp_step;
    end
  end

  // Flag memory: one row of LANES used flags per address. A row that has
  // never been written since reset reads as all free.
  logic [LANES-1:0]  flag_mem [GRP];
  logic [GRP-1:0]    row_valid_r;
  logic [LANES-1:0]  mem_q_r;
  logic              rowv_q_r;
  logic              stage_valid_r;
  logic [GRP_W-1:0]  stage_grp_r;
  logic [ADDR_W-1:0] stage_addr_r;

  logic              hit_r;
  logic [GRP_W-1:0]  hit_grp_r;
  logic [LANE_W-1:0] hit_lane_r;
  logic [LANES-1:0]  hit_word_r;
  logic [ADDR_W-1:0] hit_addr_r;
  logic [CNT_W-1:0]  used_acc_r;

  logic              mem_we;
  logic [LANES-1:0]  new_word;

  assign mem_we   = cmd.commit && hit_r;
  assign new_word = hit_word_r ^ (LANES'(1) << hit_lane_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      flag_mem[hit_grp_r] <= new_word;
    end
    if (cmd.rd) begin
      mem_q_r <= flag_mem[grp];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r   <= '0;
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= cmd.rd;
      if (mem_we) begin
        row_valid_r[hit_grp_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rowv_q_r     <= row_valid_r[grp];
      stage_grp_r  <= grp;
      stage_addr_r <= issue_addr_r;
    end
  end

  // Evaluation of one row: lane addresses, candidates, used count.
  logic [LANES-1:0]  word;
  logic [LANES-1:0]  lane_act;
  logic [LANES-1:0]  cand;
  logic [CNT_W-1:0]  row_used;
  logic              found;
  logic [LANE_W-1:0] f_lane;
  logic [ADDR_W-1:0] f_addr;

  always_comb begin
    logic [IW-1:0]     idx;
    logic [ADDR_W-1:0] lane_addr;
    word     = rowv_q_r ? mem_q_r : '0;
    lane_act = '0;
    cand     = '0;
    row_used = '0;
    found    = 1'b0;
    f_lane   = '0;
    f_addr   = '0;
    // Walking down leaves the lowest candidate lane in the result.
    for (int j = LANES - 1; j >= 0; j--) begin
      idx         = IW'(stage_grp_r) * IW'(LANES) + IW'(j);
      lane_addr   = stage_addr_r + ADDR_W'(block_size) * ADDR_W'(j);
      lane_act[j] = (idx < n_ext);
      if (op_r == OP_ALLOC) begin
        cand[j] = lane_act[j] && !word[j];
      end else begin
        cand[j] = lane_act[j] && word[j] && (lane_addr == rel_r);
      end
      row_used = row_used + CNT_W'(word[j] && lane_act[j]);
      if (cand[j]) begin
        found  = 1'b1;
        f_lane = LANE_W'(j);
        f_addr = lane_addr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r      <= 1'b0;
      used_acc_r <= '0;
    end else if (cmd.start) begin
      hit_r      <= 1'b0;
      used_acc_r <= '0;
    end else if (stage_valid_r) begin
      used_acc_r <= used_acc_r + row_used;
      if (!hit_r && found) begin
        hit_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_valid_r && !hit_r && found) begin
      hit_grp_r  <= stage_grp_r;
      hit_lane_r <= f_lane;
      hit_word_r <= word;
      hit_addr_r <= f_addr;
    end
  end

  // Result register.
  logic [CNT_W-1:0]  used_after;
  logic [CNT_W-1:0]  free_cnt;
  logic              out_valid_r;
  logic              out_success_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [CNT_W-1:0]  out_free_r;

  always_comb begin
    used_after = used_acc_r;
    if (hit_r && op_r == OP_ALLOC) begin
      used_after = used_acc_r + CNT_W'(1);
    end else if (hit_r && op_r == OP_FREE) begin
      used_after = used_acc_r - CNT_W'(1);
    end
    free_cnt = n_act - used_after;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_success_r <= hit_r;
      out_addr_r    <= (hit_r && op_r == OP_ALLOC) ? hit_addr_r : '0;
      out_free_r    <= free_cnt;
    end
  end

  assign status.scan_last = (grp == last_grp);
  assign status.out_free  = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_success       = out_success_r;
  assign out_block_address = out_addr_r;
  assign out_free_count    = out_free_r;

`ifndef ASSERT_OFF
  a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("result overwritten before it was taken");
  a_used_within_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (used_acc_r <= n_act))
    else $error("used count exceeds active block count");
  a_alloc_took_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && hit_r && op_r == OP_ALLOC) |-> !hit_word_r[hit_lane_r])
    else $error("allocation chose a block already in use");
  a_free_hit_used: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && hit_r && op_r == OP_FREE) |-> hit_word_r[hit_lane_r])
    else $error("release matched a block that was not in use");
`endif

endmodule

[rtl/fixed_block_pool_allocator.sv]
// Top level of the fixed block pool allocator: stream ports, configuration
// registers, sequencer and datapath. Depends on fbpa_pkg, fbpa_ctrl and
// fbpa_datapath.
//
// Each request transaction either allocates the lowest free block among the
// first block_count blocks, capped at MAX_BLOCKS, or releases the used block
// whose address matches. Used flags live in a memory of eight flags per row,
// and the scan reads one row per cycle through its single read port. After
// acceptance a transaction reads the rows holding the active blocks (at least
// one row is always read), evaluates the last row in a wait state and then
// commits the result. The next request is accepted at the clock edge after
// the result is loaded, while that result may still wait on out_tready; a
// result still held when the next one is ready stalls the sequencer until
// out_tready. Reset takes effect at once; rows never written since reset read
// as free, so there is no clearing pass.
module fixed_block_pool_allocator #(
  parameter int MAX_BLOCKS = fbpa_pkg::DEFAULT_MAX_BLOCKS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [31:0]                        in_tdata,   // [31:0] release_address
  input  logic                               in_tuser,   // [0] operation
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [39:0]                        out_tdata,  // [31:0] block_address,
                                                         // [38:32] free_count
  output logic                               out_tuser,  // [0] success
  input  logic                               cfg_wen,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import fbpa_pkg::*;

  localparam int LANES = SCAN_LANES;
  localparam int GRP   = (MAX_BLOCKS + LANES - 1) / LANES;
  localparam int GRP_W = (GRP > 1) ? $clog2(GRP) : 1;

  logic [ADDR_W-1:0] base_address_r;
  logic [SIZE_W-1:0] block_size_r;
  logic [CNT_W-1:0]  block_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_address_r <= BASE_ADDRESS_RESET;
      block_size_r   <= BLOCK_SIZE_RESET;
      block_count_r  <= BLOCK_COUNT_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_BASE_ADDRESS: base_address_r <= cfg_wdata[ADDR_W-1:0];
        CFG_BLOCK_SIZE:   block_size_r   <= cfg_wdata[SIZE_W-1:0];
        CFG_BLOCK_COUNT:  block_count_r  <= cfg_wdata[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ctrl_cmd_t        cmd;
  ctrl_status_t     status;
  logic [GRP_W-1:0] grp;

  logic              res_success;
  logic [ADDR_W-1:0] res_block_address;
  logic [CNT_W-1:0]  res_free_count;

  fbpa_ctrl #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .grp       (grp),
    .status    (status)
  );

  fbpa_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .grp                (grp),
    .status             (status),
    .base_address       (base_address_r),
    .block_size         (block_size_r),
    .block_count        (block_count_r),
    .in_operation       (in_tuser),
    .in_release_address (in_tdata),
    .out_valid          (out_tvalid),
    .out_ready          (out_tready),
    .out_success        (res_success),
    .out_block_address  (res_block_address),
    .out_free_count     (res_free_count)
  );

  assign out_tdata = {1'b0, res_free_count, res_block_address};
  assign out_tuser = res_success;

endmodule
